/* rtl/tgms_pkg.sv */
// ----------------------------------------------------------------------------
// tgms_pkg
// Shared types, constants and the CORDIC arctangent table for the tilt
// gesture mode switch.
// ----------------------------------------------------------------------------
package tgms_pkg;

  // Angle format and gesture window
  localparam int ANGLE_FRAC_BITS = 7;
  localparam int WINDOW_DEG      = 10;

  // Internal arithmetic
  localparam int CORDIC_STEPS = 20;
  localparam int INNER_FRAC   = 16;
  localparam int DIV_STEPS    = 25;
  localparam int CNT_W        = 5;
  localparam int RAW_W        = 16;
  localparam int DIFF_W       = RAW_W + 1;
  localparam int NUM_W        = 25;
  localparam int MAP_W        = 26;
  localparam int VEC_W        = 52;
  localparam int ZACC_W       = 26;
  localparam int TSUM_W       = 28;
  localparam int SCALE_SHIFT  = 24;
  localparam int DEG_W        = 9;
  localparam int ANG_W        = DEG_W + 1 + ANGLE_FRAC_BITS;
  localparam int WIN_W        = ANG_W + 1;
  localparam int OUT_ANG_W    = 16;
  localparam int COL_W        = 8;
  localparam int MAP_SCALE    = 180;
  localparam int MAP_OFFSET   = 90;
  localparam int ROUND_SHIFT  = INNER_FRAC - ANGLE_FRAC_BITS;

  // Configuration port
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAP_IN_LOW  = 2'd0,
    CFG_MAP_IN_HIGH = 2'd1,
    CFG_DOWN_ANGLE  = 2'd2,
    CFG_MID_ANGLE   = 2'd3
  } cfg_reg_e;

  localparam logic signed [RAW_W-1:0] RST_MAP_IN_LOW  = 16'sd265;
  localparam logic signed [RAW_W-1:0] RST_MAP_IN_HIGH = 16'sd402;
  localparam logic [DEG_W-1:0]        RST_DOWN_ANGLE  = 9'd270;
  localparam logic [DEG_W-1:0]        RST_MID_ANGLE   = 9'd180;

  // Gesture modes and their colors
  localparam logic [1:0] MODE_MAGENTA = 2'd0;
  localparam logic [1:0] MODE_BLUE    = 2'd1;
  localparam logic [1:0] MODE_YELLOW  = 2'd2;
  localparam logic [COL_W-1:0] COL_FULL = 8'd255;
  localparam logic [COL_W-1:0] COL_OFF  = 8'd0;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_DIV_DONE,
    OP_COR_INIT,
    OP_COR_STEP,
    OP_COR_DONE,
    OP_FINISH
  } dp_op_e;

  typedef struct packed {
    dp_op_e             op;
    axis_e              axis;
    logic [CNT_W-1:0]   idx;
  } dp_cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV_INIT,
    S_DIV,
    S_DIV_DONE,
    S_COR_INIT,
    S_COR,
    S_COR_DONE,
    S_OUT
  } ctrl_state_e;

  typedef struct packed {
    logic signed [RAW_W-1:0] accel_x;
    logic signed [RAW_W-1:0] accel_y;
    logic signed [RAW_W-1:0] accel_z;
  } in_word_t;

  typedef struct packed {
    logic [OUT_ANG_W-1:0] angle_x;
    logic [OUT_ANG_W-1:0] angle_y;
    logic [OUT_ANG_W-1:0] angle_z;
    logic [1:0]           mode_now;
    logic                 color_show;
    logic [COL_W-1:0]     color_red;
    logic [COL_W-1:0]     color_green;
    logic [COL_W-1:0]     color_blue;
  } out_word_t;

  // atan(2^-i) in 2^-16 degree units
  function automatic logic signed [ZACC_W-1:0] atan_step(input logic [CNT_W-1:0] i);
    logic signed [ZACC_W-1:0] v;
    unique case (i)
      5'd0:    v = 26'sd2949120;
      5'd1:    v = 26'sd1740967;
      5'd2:    v = 26'sd919879;
      5'd3:    v = 26'sd466945;
      5'd4:    v = 26'sd234379;
      5'd5:    v = 26'sd117304;
      5'd6:    v = 26'sd58666;
      5'd7:    v = 26'sd29335;
      5'd8:    v = 26'sd14668;
      5'd9:    v = 26'sd7334;
      5'd10:   v = 26'sd3667;
      5'd11:   v = 26'sd1833;
      5'd12:   v = 26'sd917;
      5'd13:   v = 26'sd458;
      5'd14:   v = 26'sd229;
      5'd15:   v = 26'sd115;
      5'd16:   v = 26'sd57;
      5'd17:   v = 26'sd29;
      5'd18:   v = 26'sd14;
      5'd19:   v = 26'sd7;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

/* rtl/tgms_ctrl.sv */
// ----------------------------------------------------------------------------
// tgms_ctrl
// Sequencer: runs three divisions, then three CORDIC passes, then hands the
// finished word to the output register.
// ----------------------------------------------------------------------------
module tgms_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output tgms_pkg::dp_cmd_t cmd_o
);

  tgms_pkg::ctrl_state_e         state_q, state_d;
  logic [tgms_pkg::CNT_W-1:0]    cnt_q, cnt_d;
  tgms_pkg::axis_e               axis_q, axis_d, axis_nxt;
  logic                          out_valid_q, out_valid_d;
  logic                          finish;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tgms_pkg::S_IDLE;
      cnt_q       <= '0;
      axis_q      <= tgms_pkg::AXIS_X;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      axis_q      <= axis_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    unique case (axis_q)
      tgms_pkg::AXIS_X: axis_nxt = tgms_pkg::AXIS_Y;
      tgms_pkg::AXIS_Y: axis_nxt = tgms_pkg::AXIS_Z;
      default:          axis_nxt = tgms_pkg::AXIS_X;
    endcase
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    axis_d     = axis_q;
    in_ready_o = 1'b0;
    finish     = 1'b0;
    cmd_o.op   = tgms_pkg::OP_NONE;
    cmd_o.axis = axis_q;
    cmd_o.idx  = cnt_q;
    unique case (state_q)
      tgms_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = tgms_pkg::OP_LOAD;
          axis_d   = tgms_pkg::AXIS_X;
          state_d  = tgms_pkg::S_DIV_INIT;
        end
      end
      tgms_pkg::S_DIV_INIT: begin
        cmd_o.op = tgms_pkg::OP_DIV_INIT;
        cnt_d    = '0;
        state_d  = tgms_pkg::S_DIV;
      end
      tgms_pkg::S_DIV: begin
        cmd_o.op = tgms_pkg::OP_DIV_STEP;
        if (cnt_q == tgms_pkg::CNT_W'(tgms_pkg::DIV_STEPS - 1)) begin
          state_d = tgms_pkg::S_DIV_DONE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      tgms_pkg::S_DIV_DONE: begin
        cmd_o.op = tgms_pkg::OP_DIV_DONE;
        axis_d   = axis_nxt;
        if (axis_q == tgms_pkg::AXIS_Z) begin
          state_d = tgms_pkg::S_COR_INIT;
        end else begin
          state_d = tgms_pkg::S_DIV_INIT;
        end
      end
      tgms_pkg::S_COR_INIT: begin
        cmd_o.op = tgms_pkg::OP_COR_INIT;
        cnt_d    = '0;
        state_d  = tgms_pkg::S_COR;
      end
      tgms_pkg::S_COR: begin
        cmd_o.op = tgms_pkg::OP_COR_STEP;
        if (cnt_q == tgms_pkg::CNT_W'(tgms_pkg::CORDIC_STEPS - 1)) begin
          state_d = tgms_pkg::S_COR_DONE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      tgms_pkg::S_COR_DONE: begin
        cmd_o.op = tgms_pkg::OP_COR_DONE;
        axis_d   = axis_nxt;
        if (axis_q == tgms_pkg::AXIS_Z) begin
          state_d = tgms_pkg::S_OUT;
        end else begin
          state_d = tgms_pkg::S_COR_INIT;
        end
      end
      tgms_pkg::S_OUT: begin
        // wait for a free output slot
        if (!out_valid_q || out_ready_i) begin
          cmd_o.op = tgms_pkg::OP_FINISH;
          finish   = 1'b1;
          state_d  = tgms_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = tgms_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (finish) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input taken while a word is in flight");

  a_div_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tgms_pkg::S_DIV) |-> (cnt_q < tgms_pkg::CNT_W'(tgms_pkg::DIV_STEPS)))
    else $error("divider step count out of range");

  a_valid_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> ($past(state_q) == tgms_pkg::S_OUT))
    else $error("output valid raised outside the finish step");

endmodule

/* rtl/tgms_dp.sv */
// ----------------------------------------------------------------------------
// tgms_dp
// Datapath: config registers, shared restoring divider for the axis map,
// shared vectoring CORDIC for atan2, gesture mode logic, output register.
// ----------------------------------------------------------------------------
module tgms_dp (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [tgms_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [tgms_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  tgms_pkg::dp_cmd_t               cmd_i,
  input  tgms_pkg::in_word_t              in_word_i,
  output tgms_pkg::out_word_t             out_word_o
);

  localparam int RW = tgms_pkg::RAW_W;
  localparam int DW = tgms_pkg::DIFF_W;
  localparam int NW = tgms_pkg::NUM_W;
  localparam int MW = tgms_pkg::MAP_W;
  localparam int AW = tgms_pkg::MAP_W + 1;
  localparam int VW = tgms_pkg::VEC_W;
  localparam int ZW = tgms_pkg::ZACC_W;
  localparam int TW = tgms_pkg::TSUM_W;
  localparam int GW = tgms_pkg::ANG_W;
  localparam int WW = tgms_pkg::WIN_W;
  localparam int FB = tgms_pkg::ANGLE_FRAC_BITS;
  localparam logic signed [TW-1:0] FULL_T = TW'(360 <<< tgms_pkg::INNER_FRAC);
  localparam logic signed [TW-1:0] HALF_T = TW'(1 <<< (tgms_pkg::ROUND_SHIFT - 1));
  localparam logic [GW-1:0] ANG_360 = GW'(360 << FB);
  localparam logic [GW-1:0] ANG_180 = GW'(180 << FB);

  // config
  logic signed [RW-1:0]            low_q, high_q;
  logic [tgms_pkg::DEG_W-1:0]      down_q, mid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q  <= tgms_pkg::RST_MAP_IN_LOW;
      high_q <= tgms_pkg::RST_MAP_IN_HIGH;
      down_q <= tgms_pkg::RST_DOWN_ANGLE;
      mid_q  <= tgms_pkg::RST_MID_ANGLE;
    end else if (cfg_we_i) begin
      unique case (tgms_pkg::cfg_reg_e'(cfg_idx_i))
        tgms_pkg::CFG_MAP_IN_LOW:  low_q  <= cfg_data_i[RW-1:0];
        tgms_pkg::CFG_MAP_IN_HIGH: high_q <= cfg_data_i[RW-1:0];
        tgms_pkg::CFG_DOWN_ANGLE:  down_q <= cfg_data_i[tgms_pkg::DEG_W-1:0];
        tgms_pkg::CFG_MID_ANGLE:   mid_q  <= cfg_data_i[tgms_pkg::DEG_W-1:0];
        default: ;
      endcase
    end
  end

  // sample capture
  logic signed [RW-1:0] raw_x_q, raw_y_q, raw_z_q, raw;

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == tgms_pkg::OP_LOAD) begin
      raw_x_q <= in_word_i.accel_x;
      raw_y_q <= in_word_i.accel_y;
      raw_z_q <= in_word_i.accel_z;
    end
  end

  always_comb begin
    unique case (cmd_i.axis)
      tgms_pkg::AXIS_X: raw = raw_x_q;
      tgms_pkg::AXIS_Y: raw = raw_y_q;
      default:          raw = raw_z_q;
    endcase
  end

  // axis map: (raw - low) * 180 / (high - low) - 90, truncating division
  logic signed [DW-1:0] diff, den;
  logic signed [NW-1:0] num;
  logic [NW-1:0]        num_mag;
  logic [DW-1:0]        den_mag;
  logic [DW-1:0]        rem_q, rem_d, dmag_q;
  logic [NW-1:0]        quo_q, quo_d;
  logic                 neg_q;
  logic [DW:0]          part;
  logic                 part_ge;
  logic signed [MW-1:0] quo_s, mapped;
  logic signed [MW-1:0] mx_q, my_q, mz_q;

  assign diff    = DW'(raw) - DW'(low_q);
  assign den     = DW'(high_q) - DW'(low_q);
  assign num     = NW'(diff) * NW'(tgms_pkg::MAP_SCALE);
  assign num_mag = num[NW-1] ? NW'(-num) : NW'(num);
  assign den_mag = den[DW-1] ? DW'(-den) : DW'(den);

  assign part    = {rem_q, quo_q[NW-1]};
  assign part_ge = (part >= {1'b0, dmag_q});

  always_comb begin
    rem_d = rem_q;
    quo_d = quo_q;
    if (cmd_i.op == tgms_pkg::OP_DIV_INIT) begin
      rem_d = '0;
      quo_d = num_mag;
    end else if (cmd_i.op == tgms_pkg::OP_DIV_STEP) begin
      rem_d = part_ge ? DW'(part - {1'b0, dmag_q}) : DW'(part);
      quo_d = {quo_q[NW-2:0], part_ge};
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (cmd_i.op == tgms_pkg::OP_DIV_INIT) begin
      dmag_q <= den_mag;
      neg_q  <= num[NW-1] ^ den[DW-1];
    end
  end

  assign quo_s  = neg_q ? -$signed(MW'(quo_q)) : $signed(MW'(quo_q));
  // equal bounds map everything to -90
  assign mapped = (den == '0) ? -MW'(tgms_pkg::MAP_OFFSET)
                              : quo_s - MW'(tgms_pkg::MAP_OFFSET);

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == tgms_pkg::OP_DIV_DONE) begin
      unique case (cmd_i.axis)
        tgms_pkg::AXIS_X: mx_q <= mapped;
        tgms_pkg::AXIS_Y: my_q <= mapped;
        default:          mz_q <= mapped;
      endcase
    end
  end

  // atan2(a, b) + 180 by vectoring CORDIC
  logic signed [AW-1:0] arg_a, arg_b, vx0, vy0;
  logic                 a_zero_q, b_neg_q;
  logic [tgms_pkg::DEG_W-1:0] off_q, off_d;
  logic signed [VW-1:0] x_q, y_q, xs, ys;
  logic signed [ZW-1:0] z_q, atan_v;
  logic signed [TW-1:0] tsum, tclamp, tround;
  logic [TW-1:0]        tshift;
  logic [GW-1:0]        ang;
  logic [GW-1:0]        angx_q, angy_q, angz_q;

  always_comb begin
    unique case (cmd_i.axis)
      tgms_pkg::AXIS_X: begin
        arg_a = -AW'(my_q);
        arg_b = -AW'(mz_q);
      end
      tgms_pkg::AXIS_Y: begin
        arg_a = -AW'(mx_q);
        arg_b = -AW'(mz_q);
      end
      default: begin
        arg_a = -AW'(my_q);
        arg_b = -AW'(mx_q);
      end
    endcase
  end

  always_comb begin
    if (arg_b[AW-1]) begin
      vx0   = -arg_b;
      vy0   = -arg_a;
      off_d = arg_a[AW-1] ? 9'd0 : 9'd360;
    end else begin
      vx0   = arg_b;
      vy0   = arg_a;
      off_d = 9'd180;
    end
  end

  assign xs     = x_q >>> cmd_i.idx;
  assign ys     = y_q >>> cmd_i.idx;
  assign atan_v = tgms_pkg::atan_step(cmd_i.idx);

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == tgms_pkg::OP_COR_INIT) begin
      x_q      <= VW'(vx0) <<< tgms_pkg::SCALE_SHIFT;
      y_q      <= VW'(vy0) <<< tgms_pkg::SCALE_SHIFT;
      z_q      <= '0;
      a_zero_q <= (arg_a == '0);
      b_neg_q  <= arg_b[AW-1];
      off_q    <= off_d;
    end else if (cmd_i.op == tgms_pkg::OP_COR_STEP) begin
      if (!y_q[VW-1]) begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + atan_v;
      end else begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - atan_v;
      end
    end
  end

  assign tsum   = $signed(TW'(off_q) << tgms_pkg::INNER_FRAC) + TW'(z_q);
  assign tclamp = tsum[TW-1] ? '0 : ((tsum > FULL_T) ? FULL_T : tsum);
  assign tround = tclamp + HALF_T;
  assign tshift = tround >>> tgms_pkg::ROUND_SHIFT;

  always_comb begin
    if (a_zero_q) begin
      ang = b_neg_q ? ANG_360 : ANG_180;
    end else begin
      ang = tshift[GW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == tgms_pkg::OP_COR_DONE) begin
      unique case (cmd_i.axis)
        tgms_pkg::AXIS_X: angx_q <= ang;
        tgms_pkg::AXIS_Y: angy_q <= ang;
        default:          angz_q <= ang;
      endcase
    end
  end

  // gesture windows on the Y angle
  logic signed [WW-1:0] ang_s, dlo, dhi, mlo, mhi;
  logic                 in_down, in_mid, trig, latch_mid;
  logic                 latch_q, latch_d;
  logic [1:0]           mode_q, mode_d;
  logic [tgms_pkg::COL_W-1:0] red, green, blue;

  assign ang_s = $signed({1'b0, angy_q});
  assign dlo = (WW'($signed({1'b0, down_q})) - WW'(tgms_pkg::WINDOW_DEG)) <<< FB;
  assign dhi = (WW'($signed({1'b0, down_q})) + WW'(tgms_pkg::WINDOW_DEG)) <<< FB;
  assign mlo = (WW'($signed({1'b0, mid_q})) - WW'(tgms_pkg::WINDOW_DEG)) <<< FB;
  assign mhi = (WW'($signed({1'b0, mid_q})) + WW'(tgms_pkg::WINDOW_DEG)) <<< FB;

  assign in_down   = (dlo < ang_s) && (ang_s < dhi);
  assign in_mid    = (mlo < ang_s) && (ang_s < mhi);
  assign trig      = in_down && !latch_q;
  assign latch_mid = trig | latch_q;
  assign latch_d   = latch_mid && !in_mid;

  always_comb begin
    mode_d = mode_q;
    red    = tgms_pkg::COL_OFF;
    green  = tgms_pkg::COL_OFF;
    blue   = tgms_pkg::COL_OFF;
    if (trig) begin
      case (mode_q)
        tgms_pkg::MODE_MAGENTA: begin
          mode_d = tgms_pkg::MODE_BLUE;
          blue   = tgms_pkg::COL_FULL;
        end
        tgms_pkg::MODE_BLUE: begin
          mode_d = tgms_pkg::MODE_YELLOW;
          red    = tgms_pkg::COL_FULL;
          green  = tgms_pkg::COL_FULL;
        end
        default: begin
          mode_d = tgms_pkg::MODE_MAGENTA;
          red    = tgms_pkg::COL_FULL;
          blue   = tgms_pkg::COL_FULL;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= tgms_pkg::MODE_MAGENTA;
      latch_q <= 1'b0;
    end else if (cmd_i.op == tgms_pkg::OP_FINISH) begin
      mode_q  <= mode_d;
      latch_q <= latch_d;
    end
  end

  // output word
  logic [31:0]         ax32, ay32, az32;
  tgms_pkg::out_word_t out_q;

  assign ax32 = 32'(angx_q);
  assign ay32 = 32'(angy_q);
  assign az32 = 32'(angz_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == tgms_pkg::OP_FINISH) begin
      out_q.angle_x     <= ax32[tgms_pkg::OUT_ANG_W-1:0];
      out_q.angle_y     <= ay32[tgms_pkg::OUT_ANG_W-1:0];
      out_q.angle_z     <= az32[tgms_pkg::OUT_ANG_W-1:0];
      out_q.mode_now    <= mode_d;
      out_q.color_show  <= trig;
      out_q.color_red   <= red;
      out_q.color_green <= green;
      out_q.color_blue  <= blue;
    end
  end

  assign out_word_o = out_q;

  a_mode_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == tgms_pkg::MODE_MAGENTA || mode_q == tgms_pkg::MODE_BLUE ||
     mode_q == tgms_pkg::MODE_YELLOW))
    else $error("gesture mode left its cycle");

  a_step_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == tgms_pkg::OP_FINISH && trig) |=>
      (out_word_o.color_show && mode_q != $past(mode_q)))
    else $error("mode step not reflected in output word");

endmodule

/* rtl/tilt_gesture_mode_switch_unit.sv */
// ----------------------------------------------------------------------------
// tilt_gesture_mode_switch_unit
// Accelerometer tilt angles (atan2) and a three-color gesture mode switch.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o / in_word_i) takes one word with
//   a raw X, Y, Z accelerometer sample. Output channel (out_valid_o /
//   out_ready_i / out_word_o) returns exactly one word per input word: three
//   tilt angles in degrees times 128, the gesture mode and the color to show.
//   Config writes (cfg_we_i, cfg_idx_i, cfg_data_i) are registered; only
//   write them while no word is in flight.
// Sequencing:
//   One word at a time. After acceptance the block runs three 25-step
//   divisions (one shared restoring divider, one division per axis) and
//   three 20-step CORDIC passes (one shared unit, one pass per axis), then
//   a finish step that loads the output register; the next word is taken
//   only after that finish step.
// Reset:
//   Config registers return to their defaults (265, 402, 270, 180), mode to
//   zero with the trigger latch armed, and the output register empties.
// Stall:
//   A finished word sits in the output register while out_ready_i is low.
//   The next word is taken and computed meanwhile; it waits in its finish
//   step until the output register is free.
// ----------------------------------------------------------------------------
module tilt_gesture_mode_switch_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [tgms_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [tgms_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  tgms_pkg::in_word_t              in_word_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output tgms_pkg::out_word_t             out_word_o
);

  // command bundle from sequencer to datapath
  tgms_pkg::dp_cmd_t cmd;

  tgms_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  tgms_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .in_word_i  (in_word_i),
    .out_word_o (out_word_o)
  );

endmodule
